// ===== hw/rtl/xsh32_pkg.sv =====
package xsh32_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VAR_W   = 3;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned NWORDS  = 4;

  localparam logic [WORD_W-1:0] GOLDEN_MUL = 32'h9E37_79BB;

  typedef enum logic [VAR_W-1:0] {
    VAR_XS128_PP = 3'd0,
    VAR_XS128_SS = 3'd1,
    VAR_XS128_P  = 3'd2,
    VAR_XR64_S   = 3'd3,
    VAR_XR64_SS  = 3'd4
  } variant_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_VARIANT = 3'd0,
    REG_SALT0   = 3'd1,
    REG_SALT1   = 3'd2,
    REG_SALT2   = 3'd3,
    REG_SALT3   = 3'd4
  } reg_idx_t;

  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCR,
    ST_OUT,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic load_seed;
    logic step;
    logic scramble;
  } dp_cmd_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                            input logic [4:0] k);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << k;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ===== hw/rtl/xsh32_ctrl.sv =====
module xsh32_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_func,
  input  logic                  out_tready,
  output logic                  in_tready,
  output logic                  out_tvalid,
  output xsh32_pkg::dp_cmd_t    cmd
);

  xsh32_pkg::ctrl_state_t state_r, state_nxt;
  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xsh32_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xsh32_pkg::ST_IDLE: begin
        if (in_acc && in_func == xsh32_pkg::FUNC_DRAW) begin
          state_nxt = xsh32_pkg::ST_SCR;
        end
      end
      xsh32_pkg::ST_SCR: begin
        state_nxt = xsh32_pkg::ST_OUT;
      end
      xsh32_pkg::ST_OUT: begin
        // a new draw may enter while the previous beat still waits
        if (in_acc && in_func == xsh32_pkg::FUNC_DRAW) begin
          state_nxt = out_tready ? xsh32_pkg::ST_SCR : xsh32_pkg::ST_HOLD;
        end else if (out_tready) begin
          state_nxt = xsh32_pkg::ST_IDLE;
        end
      end
      xsh32_pkg::ST_HOLD: begin
        if (out_tready) begin
          state_nxt = xsh32_pkg::ST_SCR;
        end
      end
      default: state_nxt = xsh32_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      xsh32_pkg::ST_IDLE: in_tready = 1'b1;
      xsh32_pkg::ST_SCR:  ;
      xsh32_pkg::ST_OUT: begin
        in_tready  = 1'b1;
        out_tvalid = 1'b1;
      end
      xsh32_pkg::ST_HOLD: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign cmd.load_seed = in_acc && in_func == xsh32_pkg::FUNC_SEED;
  assign cmd.step      = in_acc && in_func == xsh32_pkg::FUNC_DRAW;
  assign cmd.scramble  = state_r == xsh32_pkg::ST_SCR;

endmodule

// ===== hw/rtl/xsh32_dpath.sv =====
module xsh32_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [xsh32_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [xsh32_pkg::WORD_W-1:0]        cfg_wr_data,
  input  logic [xsh32_pkg::WORD_W-1:0]        seed,
  input  xsh32_pkg::dp_cmd_t                  cmd,
  output logic [xsh32_pkg::WORD_W-1:0]        result
);

  localparam int unsigned W = xsh32_pkg::WORD_W;

  logic [xsh32_pkg::VAR_W-1:0] variant_r;
  logic [W-1:0] salt_r [xsh32_pkg::NWORDS];
  logic [W-1:0] gw_r   [xsh32_pkg::NWORDS];
  logic [W-1:0] gw_nxt [xsh32_pkg::NWORDS];
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] res_r, res_nxt;

  logic [W-1:0] w2a, w3a, b64, sum03, rot_a, w1x5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= '0;
      for (int i = 0; i < xsh32_pkg::NWORDS; i++) begin
        salt_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        xsh32_pkg::REG_VARIANT: variant_r <= cfg_wr_data[xsh32_pkg::VAR_W-1:0];
        xsh32_pkg::REG_SALT0:   salt_r[0] <= cfg_wr_data;
        xsh32_pkg::REG_SALT1:   salt_r[1] <= cfg_wr_data;
        xsh32_pkg::REG_SALT2:   salt_r[2] <= cfg_wr_data;
        xsh32_pkg::REG_SALT3:   salt_r[3] <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // state advance and first scrambler stage (one multiply at most)
  always_comb begin
    w2a   = gw_r[2] ^ gw_r[0];
    w3a   = gw_r[3] ^ gw_r[1];
    b64   = gw_r[1] ^ gw_r[0];
    sum03 = gw_r[0] + gw_r[3];
    w1x5  = gw_r[1] + (gw_r[1] << 2);
    for (int i = 0; i < xsh32_pkg::NWORDS; i++) begin
      gw_nxt[i] = gw_r[i];
    end
    prod_nxt = '0;
    if (cmd.load_seed) begin
      gw_nxt[0] = salt_r[0] ^ seed;
      gw_nxt[1] = salt_r[1] ^ xsh32_pkg::rotl(seed, 5'd4);
      gw_nxt[2] = salt_r[2] ^ xsh32_pkg::rotl(seed, 5'd8);
      gw_nxt[3] = salt_r[3] ^ xsh32_pkg::rotl(seed, 5'd12);
    end else if (cmd.step) begin
      case (variant_r)
        xsh32_pkg::VAR_XS128_PP, xsh32_pkg::VAR_XS128_SS, xsh32_pkg::VAR_XS128_P: begin
          gw_nxt[0] = gw_r[0] ^ w3a;
          gw_nxt[1] = gw_r[1] ^ w2a;
          gw_nxt[2] = w2a ^ (gw_r[1] << 9);
          gw_nxt[3] = xsh32_pkg::rotl(w3a, 5'd11);
        end
        xsh32_pkg::VAR_XR64_S, xsh32_pkg::VAR_XR64_SS: begin
          gw_nxt[0] = xsh32_pkg::rotl(gw_r[0], 5'd26) ^ b64 ^ (b64 << 9);
          gw_nxt[1] = xsh32_pkg::rotl(b64, 5'd13);
        end
        default: ;
      endcase
      case (variant_r)
        xsh32_pkg::VAR_XS128_PP: prod_nxt = xsh32_pkg::rotl(sum03, 5'd7) + gw_r[0];
        xsh32_pkg::VAR_XS128_SS: prod_nxt = w1x5;
        xsh32_pkg::VAR_XS128_P:  prod_nxt = sum03;
        xsh32_pkg::VAR_XR64_S, xsh32_pkg::VAR_XR64_SS:
          prod_nxt = gw_r[0] * xsh32_pkg::GOLDEN_MUL;
        default: prod_nxt = '0;
      endcase
    end
  end

  // second scrambler stage, off the product register
  always_comb begin
    rot_a   = '0;
    res_nxt = prod_r;
    case (variant_r)
      xsh32_pkg::VAR_XS128_SS: begin
        rot_a   = xsh32_pkg::rotl(prod_r, 5'd7);
        res_nxt = rot_a + (rot_a << 3);
      end
      xsh32_pkg::VAR_XR64_SS: begin
        rot_a   = xsh32_pkg::rotl(prod_r, 5'd5);
        res_nxt = rot_a + (rot_a << 2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xsh32_pkg::NWORDS; i++) begin
        gw_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < xsh32_pkg::NWORDS; i++) begin
        gw_r[i] <= gw_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      prod_r <= prod_nxt;
    end
    if (cmd.scramble) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

// ===== hw/rtl/xoshiro32_family_generator.sv =====
// channel   | dir | tdata               | tuser
// ----------+-----+---------------------+-----------------------------
// in_       | in  | seed_value [31:0]   | func [0] (0 draw, 1 reseed)
// out_      | out | random_word [31:0]  | -
// cfg_      | in  | wr_data [31:0], addr [2:0] selects the register
//
// a reseed beat is accepted and gives no output beat
// a draw beat reaches its output beat through the product register (state step
// and first scrambler stage, the 32x32 multiplier) and then the output register
// (the rotate and small multiply of the second stage)
// one further draw is taken while an output beat waits; after that in_tready
// stays low until the waiting beat is taken
// rst_n is synchronous: state words, salts and variant clear to zero
module xoshiro32_family_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [xsh32_pkg::WORD_W-1:0]        in_tdata,   // seed_value [31:0]
  input  logic                                in_tuser,   // func [0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [xsh32_pkg::WORD_W-1:0]        out_tdata,  // random_word [31:0]
  input  logic                                cfg_wr_en,
  input  logic [xsh32_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [xsh32_pkg::WORD_W-1:0]        cfg_wr_data
);

  xsh32_pkg::dp_cmd_t cmd;

  xsh32_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  xsh32_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .seed        (in_tdata),
    .cmd         (cmd),
    .result      (out_tdata)
  );

  // a draw taken with nothing pending shows its beat once the SCR state has passed
  a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == xsh32_pkg::FUNC_DRAW && !out_tvalid
    |=> !out_tvalid ##1 out_tvalid)
    else $error("draw beat latency wrong");

  // a reseed taken with nothing pending produces no output beat
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == xsh32_pkg::FUNC_SEED && !out_tvalid
    |=> !out_tvalid)
    else $error("reseed produced an output beat");

  // scrambler only loads the output register when no beat is waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scramble |-> !out_tvalid)
    else $error("output register loaded while a beat waits");

endmodule
